>>> hdl/bfba_pkg.sv
// Shared constants, codes and control types of the best-fit block allocator.
package bfba_pkg;

  localparam int DEF_NUM_BLOCKS = 32;
  localparam int DEF_SIZE_BITS  = 16;

  localparam int COUNT_W  = 6;
  localparam int IDXIN_W  = 5;
  localparam int SIZEIN_W = 16;
  localparam int REQ_W    = 16;
  localparam int STATUS_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_BADIDX = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic search;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/best_fit_block_allocator.sv
// Top level of the best-fit block allocator: controller, datapath and checks.
//
// The block keeps a table of NUM_BLOCKS sizes and taken flags. Input beats
// arrive on in_valid/in_stall and carry an opcode: a load writes one size,
// an allocate searches the first block_count entries for the smallest free
// size that covers the request (lowest index on a tie) and marks it taken.
// Every input beat gives exactly one result beat on out_valid/out_stall with
// a status and the granted index. block_count is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is
// idle, as the block itself does not enforce this.
// A load result is registered when its beat is accepted, so loads flow at
// one per cycle while out_stall is low. An allocate reads the size table
// one entry a cycle through its single registered read port and compares
// in the cycle after each read; no new beat is taken while it searches.
// Reset marks all sizes invalid, so they read as zero, clears all taken
// flags, and sets block_count to 32. A result waits in the output register
// while out_stall is high; a new beat is taken only once that register is
// free or is being emptied.
module best_fit_block_allocator #(
  parameter int NUM_BLOCKS = bfba_pkg::DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = bfba_pkg::DEF_SIZE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bfba_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [bfba_pkg::IDXIN_W-1:0]  in_block_index,
  input  logic [bfba_pkg::SIZEIN_W-1:0] in_block_size_in,
  input  logic [bfba_pkg::REQ_W-1:0]    in_request_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bfba_pkg::STATUS_W-1:0] out_status,
  output logic [bfba_pkg::IDXIN_W-1:0]  out_granted_index
);
  import bfba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_block_index    (in_block_index),
    .in_block_size_in  (in_block_size_in),
    .in_request_size   (in_request_size),
    .cmd               (cmd),
    .sts               (sts),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index)
  );

  // A beat is only taken when the result register can receive its result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (!out_valid || !out_stall))
    else $error("input beat accepted while result register is blocked");

  // A load gives its result on the very next cycle and never reports no fit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_opcode == OP_LOAD)) |=>
      (out_valid && (out_status != ST_NOFIT) && (out_granted_index == '0)))
    else $error("load result missing or malformed");

  // Only a successful allocate carries a nonzero index.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_granted_index == '0))
    else $error("index reported with a failing status");

  // The load, start and finish commands are mutually exclusive.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.start, cmd.finish}))
    else $error("conflicting controller commands");

endmodule

>>> hdl/bfba_ctrl.sv
// Controller state machine of the best-fit block allocator.
module bfba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_opcode,
  output logic          in_stall,
  input  bfba_pkg::sts_t sts,
  output bfba_pkg::cmd_t cmd
);
  import bfba_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          if (in_opcode == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.search_done && sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/bfba_datapath.sv
// Datapath of the best-fit block allocator: size table, taken flags, search and result register.
module bfba_datapath #(
  parameter int NUM_BLOCKS = bfba_pkg::DEF_NUM_BLOCKS,
  parameter int SIZE_BITS  = bfba_pkg::DEF_SIZE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bfba_pkg::COUNT_W-1:0]   cfg_wr_data,
  input  logic [bfba_pkg::IDXIN_W-1:0]   in_block_index,
  input  logic [bfba_pkg::SIZEIN_W-1:0]  in_block_size_in,
  input  logic [bfba_pkg::REQ_W-1:0]     in_request_size,
  input  bfba_pkg::cmd_t                 cmd,
  output bfba_pkg::sts_t                 sts,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [bfba_pkg::STATUS_W-1:0]  out_status,
  output logic [bfba_pkg::IDXIN_W-1:0]   out_granted_index
);
  import bfba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int CW    = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

  logic [COUNT_W-1:0]   block_count_r;
  logic [CNT_W-1:0]     n_w;
  logic [CNT_W-1:0]     ld_addr_w;
  logic                 ld_in_range_w;

  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid_r;
  logic [NUM_BLOCKS-1:0] taken_r;

  logic [CNT_W-1:0]     rd_addr_r;
  logic                 issue_w;
  logic                 cmp_vld_r;
  logic [CNT_W-1:0]     cmp_idx_r;
  logic [SIZE_BITS-1:0] rd_size_r;
  logic                 rd_valid_r;
  logic                 rd_taken_r;
  logic [SIZE_BITS-1:0] entry_size_w;
  logic                 hit_w;

  logic [REQ_W-1:0]     req_r;
  logic                 found_r;
  logic [CNT_W-1:0]     best_idx_r;
  logic [SIZE_BITS-1:0] best_size_r;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [IDXIN_W-1:0]   out_granted_r;

  // Effective table size: the register value capped at the table depth.
  always_comb begin
    if (int'(block_count_r) > NUM_BLOCKS) begin
      n_w = CNT_W'(NUM_BLOCKS);
    end else begin
      n_w = CNT_W'(block_count_r);
    end
  end

  assign ld_addr_w     = CNT_W'(in_block_index);
  assign ld_in_range_w = (ld_addr_w < n_w);
  assign issue_w       = cmd.search && (rd_addr_r < n_w);

  assign entry_size_w = rd_valid_r ? rd_size_r : '0;
  assign hit_w = cmp_vld_r && !rd_taken_r &&
                 (CW'(entry_size_w) >= CW'(req_r)) &&
                 (!found_r || (entry_size_w < best_size_r));

  assign sts.search_done = (rd_addr_r >= n_w) && !cmp_vld_r;
  assign sts.out_free    = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      block_count_r <= cfg_wr_data;
    end
  end

  // Size table with registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && ld_in_range_w) begin
      mem[ld_addr_w[IDX_W-1:0]] <= SIZE_BITS'(in_block_size_in);
    end
    if (issue_w) begin
      rd_size_r <= mem[rd_addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      taken_r <= '0;
    end else begin
      if (cmd.load && ld_in_range_w) begin
        valid_r[ld_addr_w[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.finish && found_r) begin
        taken_r[best_idx_r[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_w) begin
      rd_valid_r <= valid_r[rd_addr_r[IDX_W-1:0]];
      rd_taken_r <= taken_r[rd_addr_r[IDX_W-1:0]];
      cmp_idx_r  <= rd_addr_r;
    end
    if (cmd.start) begin
      req_r <= in_request_size;
    end
    if (hit_w) begin
      best_idx_r  <= cmp_idx_r;
      best_size_r <= entry_size_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      cmp_vld_r <= issue_w;
      if (cmd.start) begin
        rd_addr_r <= '0;
        found_r   <= 1'b0;
      end else begin
        if (issue_w) begin
          rd_addr_r <= rd_addr_r + CNT_W'(1);
        end
        if (hit_w) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load || cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r  <= ld_in_range_w ? ST_OK : ST_BADIDX;
      out_granted_r <= '0;
    end else if (cmd.finish) begin
      out_status_r  <= found_r ? ST_OK : ST_NOFIT;
      out_granted_r <= found_r ? best_idx_r[IDXIN_W-1:0] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_r;

endmodule
